// ===== sv/tet_pkg.sv =====
// Shared types and constants of the timer expiry table.
// Used by the interfaces, the generic RAM users and the top level.
package tet_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TID_W   = 5;
  localparam int unsigned THR_W   = 4;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned SLOT_W  = 5;

  // Operation codes of an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_SLEEP  = 2'd1,
    OP_ARM    = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  // Kind codes of a result transaction.
  typedef enum logic [KIND_W-1:0] {
    K_CREATED  = 3'd0,
    K_ERROR    = 3'd1,
    K_ACCEPTED = 3'd2,
    K_WAKE     = 3'd3,
    K_SIGNAL   = 3'd4,
    K_DONE     = 3'd5
  } kind_e;

  // One result item as held in the output register.
  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  signal;
    logic              reschedule;
    logic              last;
  } result_t;

endpackage

// ===== sv/tet_if.sv =====
// Valid/ready channel interfaces for requests and results of the timer table.
// Depends on tet_pkg for the field widths.
interface tet_in_if;
  logic                          valid;
  logic                          ready;
  logic [tet_pkg::OP_W-1:0]      operation;
  logic [tet_pkg::TIME_W-1:0]    now_ms;
  logic [tet_pkg::TIME_W-1:0]    delay_ms;
  logic [tet_pkg::TID_W-1:0]     timer_id;
  logic [tet_pkg::THR_W-1:0]     thread_id;
  logic [tet_pkg::TAG_W-1:0]     signal_tag;

  modport source (output valid, operation, now_ms, delay_ms, timer_id, thread_id,
                  signal_tag, input ready);
  modport sink   (input valid, operation, now_ms, delay_ms, timer_id, thread_id,
                  signal_tag, output ready);
endinterface

interface tet_out_if;
  logic                          valid;
  logic                          ready;
  logic [tet_pkg::KIND_W-1:0]    kind;
  logic [tet_pkg::SLOT_W-1:0]    slot_out;
  logic [tet_pkg::TAG_W-1:0]     signal_out;
  logic                          reschedule;
  logic                          last;

  modport source (output valid, kind, slot_out, signal_out, reschedule, last,
                  input ready);
  modport sink   (input valid, kind, slot_out, signal_out, reschedule, last,
                  output ready);
endinterface

// ===== sv/timer_expiry_table_top.sv =====
// Timer expiry table: signal timers and per-thread sleep timers over two RAMs.
// Create, sleep and arm are accepted in IDLE, executed in EXEC, and the result is
// registered in the output register; a new request is taken only back in IDLE. A
// tick scans one slot per cycle through the expiry RAM read port while no hit stalls at the output.
// Reset clears all flag vectors at once; the RAMs are not cleared, since an expiry
// or tag is read only for an entry that was written before.
module timer_expiry_table_top #(
  parameter int unsigned TIMER_SLOTS  = 32,
  parameter int unsigned THREAD_SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tet_in_if.sink    in_i,
  tet_out_if.source out_o
);

  localparam int unsigned NSLOTS = TIMER_SLOTS + THREAD_SLOTS;
  localparam int unsigned AW     = $clog2(NSLOTS);
  localparam int unsigned TW     = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned SW     = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX   = AW'(NSLOTS - 1);
  localparam logic [AW-1:0] THR_BASE   = AW'(TIMER_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // Flag vectors.
  logic [TIMER_SLOTS-1:0]  taken_q, taken_d;
  logic [TIMER_SLOTS-1:0]  waiting_q, waiting_d;
  logic [TIMER_SLOTS-1:0]  armed_q, armed_d;
  logic [THREAD_SLOTS-1:0] sleeper_q, sleeper_d;
  logic                    woke_q, woke_d;
  logic [AW-1:0]           idx_q, idx_d;

  // Latched request fields.
  tet_pkg::op_e                op_q;
  logic [tet_pkg::TIME_W-1:0]  now_q;
  logic [tet_pkg::TIME_W-1:0]  delay_q;
  logic [tet_pkg::TID_W-1:0]   tid_q;
  logic [tet_pkg::THR_W-1:0]   thr_q;
  logic [tet_pkg::TAG_W-1:0]   tag_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  tet_pkg::result_t out_q, out_d;
  logic             can_out;

  // RAM ports.
  logic                       exp_we, exp_re;
  logic [AW-1:0]              exp_waddr, exp_raddr;
  logic [tet_pkg::TIME_W-1:0] exp_wdata, exp_rdata;
  logic                       tag_we, tag_re;
  logic [TW-1:0]              tag_waddr, tag_raddr;
  logic [tet_pkg::TAG_W-1:0]  tag_rdata;

  // Combinational helpers.
  logic                       free_found;
  logic [TW-1:0]              free_idx;
  logic [tet_pkg::TIME_W-1:0] sum;
  logic                       arm_ok, sleep_ok;
  logic                       in_timer;
  logic [AW-1:0]              sidx_full, nidx;
  logic [SW-1:0]              sidx;
  logic                       slot_armed, hit;

  tet_ram #(.WIDTH(tet_pkg::TIME_W), .DEPTH(NSLOTS)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (exp_wdata),
    .re_i    (exp_re),
    .raddr_i (exp_raddr),
    .rdata_o (exp_rdata)
  );

  tet_ram #(.WIDTH(tet_pkg::TAG_W), .DEPTH(TIMER_SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // Lowest free timer id.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!taken_q[i]) begin
        free_found = 1'b1;
        free_idx   = TW'(i);
      end
    end
  end

  assign sum      = now_q + delay_q;
  assign arm_ok   = (32'(tid_q) < TIMER_SLOTS) && waiting_q[tid_q[TW-1:0]];
  assign sleep_ok = 32'(thr_q) < THREAD_SLOTS;

  // Scan position decode: timer slots first, then sleep slots.
  assign in_timer   = 32'(idx_q) < TIMER_SLOTS;
  assign sidx_full  = idx_q - THR_BASE;
  assign sidx       = sidx_full[SW-1:0];
  assign nidx       = idx_q + AW'(1);
  assign slot_armed = in_timer ? armed_q[idx_q[TW-1:0]] : sleeper_q[sidx];
  assign hit        = slot_armed && (exp_rdata < now_q);

  assign can_out  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // Sequencer: executes one request, or scans all slots for a tick.
  always_comb begin
    state_d     = state_q;
    taken_d     = taken_q;
    waiting_d   = waiting_q;
    armed_d     = armed_q;
    sleeper_d   = sleeper_q;
    woke_d      = woke_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    exp_we      = 1'b0;
    exp_waddr   = '0;
    exp_wdata   = sum;
    exp_re      = 1'b0;
    exp_raddr   = '0;
    tag_we      = 1'b0;
    tag_waddr   = free_idx;
    tag_re      = 1'b0;
    tag_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_q == tet_pkg::OP_TICK) begin
          woke_d    = 1'b0;
          idx_d     = '0;
          exp_re    = 1'b1;
          tag_re    = 1'b1;
          state_d   = ST_SCAN;
        end else if (can_out) begin
          out_valid_d      = 1'b1;
          out_d.kind       = tet_pkg::K_ERROR;
          out_d.slot       = '0;
          out_d.signal     = '0;
          out_d.reschedule = 1'b0;
          out_d.last       = 1'b1;
          state_d          = ST_IDLE;
          case (op_q)
            tet_pkg::OP_CREATE: begin
              if (free_found) begin
                taken_d[free_idx]   = 1'b1;
                waiting_d[free_idx] = 1'b1;
                armed_d[free_idx]   = 1'b0;
                tag_we              = 1'b1;
                out_d.kind          = tet_pkg::K_CREATED;
                out_d.slot          = tet_pkg::SLOT_W'(free_idx);
              end
            end
            tet_pkg::OP_SLEEP: begin
              if (sleep_ok) begin
                sleeper_d[thr_q[SW-1:0]] = 1'b1;
                exp_we      = 1'b1;
                exp_waddr   = THR_BASE + AW'(thr_q);
                out_d.kind  = tet_pkg::K_ACCEPTED;
                out_d.slot  = tet_pkg::SLOT_W'(thr_q);
              end
            end
            default: begin
              if (arm_ok) begin
                waiting_d[tid_q[TW-1:0]] = 1'b0;
                armed_d[tid_q[TW-1:0]]   = 1'b1;
                exp_we      = 1'b1;
                exp_waddr   = AW'(tid_q);
                out_d.kind  = tet_pkg::K_ACCEPTED;
                out_d.slot  = tid_q;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!hit || can_out) begin
          if (hit) begin
            out_valid_d      = 1'b1;
            out_d.reschedule = 1'b0;
            out_d.last       = 1'b0;
            if (in_timer) begin
              armed_d[idx_q[TW-1:0]] = 1'b0;
              out_d.kind   = tet_pkg::K_SIGNAL;
              out_d.slot   = tet_pkg::SLOT_W'(idx_q);
              out_d.signal = tag_rdata;
            end else begin
              sleeper_d[sidx] = 1'b0;
              woke_d          = 1'b1;
              out_d.kind      = tet_pkg::K_WAKE;
              out_d.slot      = tet_pkg::SLOT_W'(sidx);
              out_d.signal    = '0;
            end
          end
          if (idx_q == LAST_IDX) begin
            state_d = ST_DONE;
          end else begin
            idx_d     = nidx;
            exp_re    = 1'b1;
            exp_raddr = nidx;
            tag_re    = 32'(nidx) < TIMER_SLOTS;
            tag_raddr = nidx[TW-1:0];
          end
        end
      end
      ST_DONE: begin
        if (can_out) begin
          out_valid_d      = 1'b1;
          out_d.kind       = tet_pkg::K_DONE;
          out_d.slot       = '0;
          out_d.signal     = '0;
          out_d.reschedule = woke_q;
          out_d.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      taken_q     <= '0;
      waiting_q   <= '0;
      armed_q     <= '0;
      sleeper_q   <= '0;
      woke_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      waiting_q   <= waiting_d;
      armed_q     <= armed_d;
      sleeper_q   <= sleeper_d;
      woke_q      <= woke_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: request fields and the result.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= tet_pkg::op_e'(in_i.operation);
      now_q   <= in_i.now_ms;
      delay_q <= in_i.delay_ms;
      tid_q   <= in_i.timer_id;
      thr_q   <= in_i.thread_id;
      tag_q   <= in_i.signal_tag;
    end
    out_q <= out_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.slot_out   = out_q.slot;
  assign out_o.signal_out = out_q.signal;
  assign out_o.reschedule = out_q.reschedule;
  assign out_o.last       = out_q.last;

  // A timer is never both waiting and armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (waiting_q & armed_q) == '0)
    else $error("timer both waiting and armed");

  // Waiting and armed timers always hold a taken id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((waiting_q | armed_q) & ~taken_q) == '0)
    else $error("timer state on a free id");

  // The scan index stays inside the slot range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (32'(idx_q) < NSLOTS))
    else $error("scan index out of range");

  // A hit that cannot be delivered holds the scan position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && hit && !can_out) |=> (state_q == ST_SCAN) && $stable(idx_q))
    else $error("scan advanced over a stalled result");

  // Done items always close the transaction sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == tet_pkg::K_DONE) |-> out_q.last)
    else $error("done item without last");

endmodule

// ===== sv/tet_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; contents are not reset.
module tet_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
